/* sv/urls_pkg.sv */
// Shared types, codes and constants of the UART receive ring line splitter.
package urls_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int MAX_DELIM_DEF = 4;

    localparam logic [8:0]  LINE_CAP      = 9'd256;
    localparam logic [31:0] DELIM_RST     = 32'h0000_000A;
    localparam logic [2:0]  DELIM_LEN_RST = 3'd1;
    localparam logic [8:0]  MAX_LEN_RST   = 9'd256;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_OPEN    = 2'd2,
        OP_CLOSE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_DELIMITER = 2'd0,
        CFG_DELIM_LEN = 2'd1,
        CFG_MAX_LEN   = 2'd2
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_EMPTY     = 4'd0,
        ST_BYTE      = 4'd1,
        ST_DELIM_END = 4'd2,
        ST_LEN_END   = 4'd3,
        ST_STORED    = 4'd4,
        ST_OVERFLOW  = 4'd5,
        ST_DROPPED   = 4'd6,
        ST_OPENED    = 4'd7,
        ST_REFUSED   = 4'd8,
        ST_CLOSED    = 4'd9
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [31:0] delimiter;
        logic [2:0]  delim_len;
        logic [8:0]  max_len;
    } t_cfg;

    typedef struct packed {
        logic [8:0] count;
        logic       delim_end;
        logic       len_end;
    } t_line_res;

endpackage

/* sv/urls_in_if.sv */
// Input channel: one operation item with its received byte.
interface urls_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

/* sv/urls_out_if.sv */
// Output channel: one result item for each operation.
interface urls_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [7:0] data;
    logic [8:0] line_count;
    logic [7:0] unread_count;
    logic       is_open;

    modport source (output valid, output status, output data, output line_count,
                    output unread_count, output is_open, input ready);
    modport sink (input valid, input status, input data, input line_count,
                  input unread_count, input is_open, output ready);
endinterface

/* sv/urls_line_unit.sv */
// Line tracker: counts popped bytes and detects delimiter and length line ends.
module urls_line_unit
    import urls_pkg::*;
#(
    parameter int MAX_DELIM = MAX_DELIM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_pop,
    input  logic [7:0] i_byte,
    output t_line_res  o_res
);

    localparam int WIN_W = 8 * MAX_DELIM;

    logic [WIN_W-1:0] r_recent;
    logic [8:0]       r_line;
    logic [WIN_W-1:0] n_recent;
    logic [8:0]       n_line;

    logic [WIN_W+7:0] cat;
    logic [63:0]      delim_ext;
    logic [3:0]       dlen;
    logic [8:0]       limit;
    logic [8:0]       count;
    logic             mismatch;
    logic             hit;
    logic             len_hit;

    always_comb begin
        cat       = {r_recent, i_byte};
        n_recent  = cat[WIN_W-1:0];
        delim_ext = {32'd0, i_cfg.delimiter};

        dlen = {1'b0, i_cfg.delim_len};
        if (dlen == 4'd0) begin
            dlen = 4'd1;
        end else if (dlen > 4'(MAX_DELIM)) begin
            dlen = 4'(MAX_DELIM);
        end

        limit = i_cfg.max_len;
        if (limit == 9'd0 || limit > LINE_CAP) begin
            limit = LINE_CAP;
        end

        count = (r_line >= LINE_CAP) ? LINE_CAP : r_line + 9'd1;

        // Compare the newest bytes against the delimiter, newest byte first.
        mismatch = 1'b0;
        for (int i = 0; i < MAX_DELIM; i++) begin
            if (4'(i) < dlen && n_recent[8*i +: 8] != delim_ext[8*i +: 8]) begin
                mismatch = 1'b1;
            end
        end
        hit     = (count >= 9'(dlen)) && !mismatch;
        len_hit = !hit && (count >= limit);

        n_line = (hit || len_hit) ? 9'd0 : count;

        o_res.count     = i_pop ? count : r_line;
        o_res.delim_end = hit;
        o_res.len_end   = len_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_line   <= 9'd0;
        end else if (i_pop) begin
            r_recent <= n_recent;
            r_line   <= n_line;
        end
    end

endmodule

/* sv/uart_rx_ring_line_splitter.sv */
// Top level of the UART receive ring buffer with line splitting.
// A result item is registered by the execute state, which follows the accept cycle
// and waits for room in the output register; no new item is taken before it ends.
// The ring memory is read on accept; pointers, line state and ring are updated in execute.
// Reset is synchronous and active low: pointers, port flag, line state and configuration
// return to their defaults; the ring memory is not cleared and needs no clearing pass.
module uart_rx_ring_line_splitter
    import urls_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_DELIM = MAX_DELIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    urls_in_if.sink     i_in,
    urls_out_if.source  o_out
);

    // Pointers index the ring; the fill count needs one more bit to hold DEPTH itself.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter <= DELIM_RST;
            r_cfg.delim_len <= DELIM_LEN_RST;
            r_cfg.max_len   <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DELIMITER: r_cfg.delimiter <= i_cfg_data;
                CFG_DELIM_LEN: r_cfg.delim_len <= i_cfg_data[2:0];
                CFG_MAX_LEN:   r_cfg.max_len   <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Control state of the ring.
    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic             r_open, n_open;

    // The accepted item waits here while the ring memory read completes.
    t_op        r_op;
    logic [7:0] r_rx;

    // Ring memory: one write port, one registered read port.
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_mem_q;
    logic       mem_we;

    // Output register; it parts the result from the next accepted item.
    logic       r_out_valid;
    t_status    r_status, n_status;
    logic [7:0] r_data, n_data;
    logic [8:0] r_line_count;
    logic [7:0] r_unread, n_unread;
    logic       r_is_open;

    logic       in_acc;
    logic       out_free;
    logic       exec_done;
    logic       pop;
    t_line_res  line_res;

    logic [PTR_W-1:0] wp_adv;
    logic [PTR_W-1:0] rp_adv;
    logic [CNT_W-1:0] fill;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign wp_adv = (r_wp == PTR_LAST) ? '0 : r_wp + PTR_W'(1);
    assign rp_adv = (r_rp == PTR_LAST) ? '0 : r_rp + PTR_W'(1);

    urls_line_unit #(
        .MAX_DELIM (MAX_DELIM)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pop   (pop),
        .i_byte  (r_mem_q),
        .o_res   (line_res)
    );

    // Next state: the item executes once the output register has room for its result.
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_open    = r_open;
        n_status  = ST_EMPTY;
        n_data    = 8'd0;
        mem_we    = 1'b0;
        pop       = 1'b0;
        exec_done = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    exec_done = 1'b1;
                    n_state   = S_IDLE;
                    unique case (r_op)
                        OP_RECEIVE: begin
                            if (!r_open) begin
                                n_status = ST_DROPPED;
                            end else if (wp_adv == r_rp) begin
                                // The ring is full: the port closes and the byte is lost.
                                n_open   = 1'b0;
                                n_status = ST_OVERFLOW;
                            end else begin
                                mem_we   = 1'b1;
                                n_wp     = wp_adv;
                                n_status = ST_STORED;
                            end
                        end
                        OP_READ: begin
                            if (r_open && r_rp != r_wp) begin
                                pop    = 1'b1;
                                n_rp   = rp_adv;
                                n_data = r_mem_q;
                                priority if (line_res.delim_end) begin
                                    n_status = ST_DELIM_END;
                                end else if (line_res.len_end) begin
                                    n_status = ST_LEN_END;
                                end else begin
                                    n_status = ST_BYTE;
                                end
                            end
                        end
                        OP_OPEN: begin
                            if (r_open) begin
                                n_status = ST_REFUSED;
                            end else begin
                                n_wp     = '0;
                                n_rp     = '0;
                                n_open   = 1'b1;
                                n_status = ST_OPENED;
                            end
                        end
                        OP_CLOSE: begin
                            n_open   = 1'b0;
                            n_status = ST_CLOSED;
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Bytes waiting after this step, taken modulo the ring depth.
        if (n_wp >= n_rp) begin
            fill = {1'b0, n_wp} - {1'b0, n_rp};
        end else begin
            fill = {1'b0, n_wp} + CNT_W'(DEPTH) - {1'b0, n_rp};
        end
        n_unread = n_open ? 8'(fill) : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_open  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_open  <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op <= t_op'(i_in.op);
            r_rx <= i_in.rx_byte;
        end
    end

    // The read is issued in the accept cycle, so no write to the same slot can be pending.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= r_rx;
        end
        if (in_acc) begin
            r_mem_q <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_status     <= n_status;
            r_data       <= n_data;
            r_line_count <= line_res.count;
            r_unread     <= n_unread;
            r_is_open    <= n_open;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.data         = r_data;
    assign o_out.line_count   = r_line_count;
    assign o_out.unread_count = r_unread;
    assign o_out.is_open      = r_is_open;

endmodule

/* sv/urls_checker.sv */
// Port-level checks of the line splitter and their attachment to the top level.
module urls_checker
    import urls_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_status,
    input logic [7:0] i_data,
    input logic [7:0] i_unread,
    input logic       i_is_open
);

    logic popped;
    assign popped = (i_status == ST_BYTE) || (i_status == ST_DELIM_END)
                 || (i_status == ST_LEN_END);

    a_data_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !popped |-> i_data == 8'd0)
        else $error("data is non-zero on a result without a popped byte");

    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_open |-> i_unread == 8'd0)
        else $error("bytes reported waiting while the port is closed");

    a_open_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OPENED |-> i_is_open && i_unread == 8'd0)
        else $error("open did not leave an open, empty ring");

    a_close_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OVERFLOW || i_status == ST_CLOSED
                        || i_status == ST_DROPPED) |-> !i_is_open)
        else $error("port reported open after a closing or dropping result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
                                       && $stable(i_data))
        else $error("stalled result item changed");

endmodule

bind uart_rx_ring_line_splitter urls_checker u_urls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_data      (o_out.data),
    .i_unread    (o_out.unread_count),
    .i_is_open   (o_out.is_open)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the UART receive ring buffer with line splitting.
`timescale 1ns / 1ps

module testbench;
    import urls_pkg::*;

    // One expected result item, as the ring and line logic should produce it.
    typedef struct {
        t_status    status;
        logic [7:0] data;
        logic [8:0] line_count;
        logic [7:0] unread_count;
        logic       is_open;
    } ring_result_t;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASE_COUNT  = 6;
    localparam int REPORT_LIMIT = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    urls_in_if  in_ch ();
    urls_out_if out_ch ();

    uart_rx_ring_line_splitter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow copy of the block's state, kept in step with every accepted item.
    logic [7:0]  ring_shadow [DEPTH_DEF];
    logic [7:0]  wr_ptr;
    logic [7:0]  rd_ptr;
    logic        port_flag;
    logic [23:0] tail_bytes;
    logic [8:0]  line_len;
    logic [31:0] delim_word;
    logic [2:0]  delim_cnt;
    logic [8:0]  len_limit;

    ring_result_t pending_results[$];
    ring_result_t want;

    // Shared control between the stimulus, the receiver and the checker.
    bit steady;
    int hold_request;
    int hold_left;
    int fail_count;
    int items_sent;
    int results_checked;
    int overflow_seen;
    int delim_ends;
    int len_ends;
    int cycle_count;

    // The clock runs with a 12 ns period, starting low so that the first rising
    // edge falls half a period into the run.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // A watchdog on the cycle count: a hung handshake must never hang the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still pending.",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void reset_ring_shadow();
        wr_ptr     = '0;
        rd_ptr     = '0;
        port_flag  = 1'b0;
        tail_bytes = '0;
        line_len   = '0;
        delim_word = DELIM_RST;
        delim_cnt  = DELIM_LEN_RST;
        len_limit  = MAX_LEN_RST;
    endfunction

    // The delimiter length in use: zero counts as one, and anything above the
    // widest supported delimiter is clipped to it.
    function automatic int active_delim_len();
        if (delim_cnt == 3'd0) begin
            return 1;
        end
        if (int'(delim_cnt) > MAX_DELIM_DEF) begin
            return MAX_DELIM_DEF;
        end
        return int'(delim_cnt);
    endfunction

    // The delimiter can only match once the line holds at least as many bytes
    // as the delimiter has; the newest byte is compared with bits 7:0.
    function automatic bit delimiter_hit(logic [7:0] popped, int cnt);
        int          n;
        logic [31:0] win;
        n   = active_delim_len();
        win = {tail_bytes, popped};
        if (cnt < n) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (win[8*i +: 8] != delim_word[8*i +: 8]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Works out the result of one operation and advances the shadow state.
    function automatic ring_result_t predict_ring_step(t_op op, logic [7:0] rx_byte);
        ring_result_t r;
        logic [7:0]   nxt;
        logic [7:0]   popped;
        int           limit;
        int           cnt;
        r.status     = ST_EMPTY;
        r.data       = '0;
        r.line_count = line_len;
        case (op)
            OP_RECEIVE: begin
                nxt = wr_ptr + 8'd1;
                if (!port_flag) begin
                    r.status = ST_DROPPED;
                end else if (nxt == rd_ptr) begin
                    port_flag = 1'b0;
                    r.status  = ST_OVERFLOW;
                end else begin
                    ring_shadow[wr_ptr] = rx_byte;
                    wr_ptr   = nxt;
                    r.status = ST_STORED;
                end
            end
            OP_READ: begin
                if (port_flag && rd_ptr != wr_ptr) begin
                    popped = ring_shadow[rd_ptr];
                    rd_ptr = rd_ptr + 8'd1;
                    limit  = (len_limit == 9'd0 || len_limit > LINE_CAP) ?
                             int'(LINE_CAP) : int'(len_limit);
                    cnt    = int'(line_len) + 1;
                    if (cnt > int'(LINE_CAP)) begin
                        cnt = int'(LINE_CAP);
                    end
                    r.data       = popped;
                    r.line_count = cnt[8:0];
                    // The delimiter wins when both conditions end the line.
                    if (delimiter_hit(popped, cnt)) begin
                        r.status = ST_DELIM_END;
                        cnt      = 0;
                    end else if (cnt >= limit) begin
                        r.status = ST_LEN_END;
                        cnt      = 0;
                    end else begin
                        r.status = ST_BYTE;
                    end
                    tail_bytes = {tail_bytes[15:0], popped};
                    line_len   = cnt[8:0];
                end
            end
            OP_OPEN: begin
                if (port_flag) begin
                    r.status = ST_REFUSED;
                end else begin
                    wr_ptr    = '0;
                    rd_ptr    = '0;
                    port_flag = 1'b1;
                    r.status  = ST_OPENED;
                end
            end
            default: begin
                port_flag = 1'b0;
                r.status  = ST_CLOSED;
            end
        endcase
        r.unread_count = port_flag ? (wr_ptr - rd_ptr) : 8'd0;
        r.is_open      = port_flag;
        return r;
    endfunction

    // Offers one item, with a random gap in front of it unless the run is in a
    // steady stretch, and records its expected result once it is accepted. The
    // valid line stays high after acceptance so that back-to-back items follow.
    task automatic send_item(input t_op op, input logic [7:0] rx_byte);
        if (!steady) begin
            while ($urandom_range(99) < 26) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.rx_byte <= rx_byte;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        pending_results.push_back(predict_ring_step(op, rx_byte));
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_ring_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes all three line rules in consecutive cycles; only called while idle.
    task automatic set_line_rules(input logic [31:0] delim, input logic [2:0] dlen,
                                  input logic [8:0] mlen);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DELIMITER;
        cfg_data  <= delim;
        @(posedge i_clk);
        delim_word = delim;
        cfg_index <= CFG_DELIM_LEN;
        cfg_data  <= {29'd0, dlen};
        @(posedge i_clk);
        delim_cnt  = dlen;
        cfg_index <= CFG_MAX_LEN;
        cfg_data  <= {23'd0, mlen};
        @(posedge i_clk);
        len_limit  = mlen;
        cfg_we    <= 1'b0;
    endtask

    // A byte that is often the final delimiter character, so lines do end.
    function automatic logic [7:0] line_byte();
        if ($urandom_range(99) < 40) begin
            return delim_word[7:0];
        end
        return 8'($urandom_range(255));
    endfunction

    // Port control straight out of reset: a read and a receive while closed,
    // closing a closed port, opening, a refused second open and a read of the empty ring.
    task automatic test_port_control();
        send_item(OP_READ, 8'h00);
        send_item(OP_RECEIVE, 8'hFF);
        send_item(OP_CLOSE, 8'h00);
        send_item(OP_OPEN, 8'hFF);
        send_item(OP_OPEN, 8'h00);
        send_item(OP_READ, 8'hFF);
        wait_ring_drained();
    endtask

    // With the reset rules a line feed ends the line after an ordinary byte.
    task automatic test_default_delimiter();
        send_item(OP_RECEIVE, 8'h00);
        send_item(OP_RECEIVE, 8'h0A);
        send_item(OP_READ, 8'h00);
        send_item(OP_READ, 8'h00);
        wait_ring_drained();
    endtask

    // Rules at and beyond their limits. A one-byte limit on a delimiter byte
    // shows that the delimiter takes precedence; a zero delimiter length acts as
    // one and an oversized one as four; a zero or oversized line limit acts as
    // 256. The last pair of reads shows a short line that cannot match yet.
    task automatic test_line_rule_extremes();
        set_line_rules(32'h0000_00FF, 3'd0, 9'd1);
        send_item(OP_RECEIVE, 8'hFF);
        send_item(OP_READ, 8'h00);
        wait_ring_drained();
        set_line_rules(32'hFFFF_FFFF, 3'd7, 9'd0);
        repeat (4) send_item(OP_RECEIVE, 8'hFF);
        repeat (4) send_item(OP_READ, 8'h00);
        repeat (2) send_item(OP_RECEIVE, 8'hFF);
        repeat (2) send_item(OP_READ, 8'h00);
        wait_ring_drained();
        set_line_rules(DELIM_RST, DELIM_LEN_RST, 9'h1FF);
        send_item(OP_RECEIVE, 8'h5A);
        send_item(OP_READ, 8'h00);
        wait_ring_drained();
    endtask

    // Fills the ring from freshly opened pointers until the one spare slot is
    // reached, so that the next byte closes the port. Afterwards a receive is
    // dropped, a read sees a closed port, and reopening discards the contents.
    task automatic test_ring_overflow();
        send_item(OP_CLOSE, 8'($urandom_range(255)));
        send_item(OP_OPEN, 8'($urandom_range(255)));
        repeat (DEPTH_DEF) send_item(OP_RECEIVE, 8'($urandom_range(255)));
        send_item(OP_RECEIVE, 8'($urandom_range(255)));
        send_item(OP_READ, 8'($urandom_range(255)));
        send_item(OP_OPEN, 8'($urandom_range(255)));
        send_item(OP_READ, 8'($urandom_range(255)));
        wait_ring_drained();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // block backs up and stalls its input; the sender then pauses for all results.
    task automatic test_output_backpressure();
        send_item(OP_OPEN, 8'($urandom_range(255)));
        hold_request = HOLD_CYCLES;
        repeat (15) begin
            send_item(OP_RECEIVE, line_byte());
            send_item(OP_READ, 8'($urandom_range(255)));
        end
        wait_ring_drained();
    endtask

    // One phase of random lines under the current rules. Most items are
    // receives and reads, some of them whole delimiter sequences, with an
    // occasional close or open as noise.
    task automatic run_line_phase(input int n_items);
        int sent;
        int pick;
        int n;
        sent = 0;
        send_item(OP_OPEN, 8'($urandom_range(255)));
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                n = active_delim_len();
                for (int k = n - 1; k >= 0; k--) begin
                    send_item(OP_RECEIVE, delim_word[8*k +: 8]);
                end
                sent += n;
            end else if (pick < 45) begin
                send_item(OP_RECEIVE, line_byte());
                sent++;
            end else if (pick < 93) begin
                send_item(OP_READ, 8'($urandom_range(255)));
                sent++;
            end else if (pick < 96) begin
                send_item(OP_CLOSE, 8'($urandom_range(255)));
                sent++;
            end else begin
                send_item(OP_OPEN, 8'($urandom_range(255)));
                sent++;
            end
        end
        wait_ring_drained();
    endtask

    // Random lines under a series of rule settings, the extremes among them.
    // The third phase runs with no idling on either side.
    task automatic test_random_lines();
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_line_rules(32'h0000_000A, 3'd1, 9'd256);
                1: set_line_rules(32'h0000_0D0A, 3'd2, 9'd1);
                2: set_line_rules(32'hFFFF_FFFF, 3'd4, 9'd256);
                3: set_line_rules(32'h0000_0000, 3'd3, 9'd5);
                4: set_line_rules($urandom, 3'($urandom_range(1, 4)),
                                  9'($urandom_range(1, 256)));
                default: set_line_rules($urandom, 3'd4, 9'd3);
            endcase
            steady = (p == 2);
            run_line_phase(PHASE_ITEMS);
            steady = 1'b0;
        end
    endtask

    // The receiver: random stalls, none in a steady stretch, and a long hold
    // when a test asks for one, counted down here one cycle at a time.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (!steady && $urandom_range(99) < 26) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // The checker compares every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("[%0t] result with nothing pending: status %0d data %02h",
                             $time, out_ch.status, out_ch.data);
                end
            end else begin
                want = pending_results.pop_front();
                if (want.status == ST_OVERFLOW) begin
                    overflow_seen++;
                end
                if (want.status == ST_DELIM_END) begin
                    delim_ends++;
                end
                if (want.status == ST_LEN_END) begin
                    len_ends++;
                end
                if (out_ch.status !== want.status || out_ch.data !== want.data ||
                    out_ch.line_count !== want.line_count ||
                    out_ch.unread_count !== want.unread_count ||
                    out_ch.is_open !== want.is_open) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("[%0t] mismatch: expected st %0d d %02h ln %0d un %0d op %0b",
                                 $time, want.status, want.data, want.line_count,
                                 want.unread_count, want.is_open);
                        $display("             actual   st %0d d %02h ln %0d un %0d op %0b",
                                 out_ch.status, out_ch.data, out_ch.line_count,
                                 out_ch.unread_count, out_ch.is_open);
                    end
                end
            end
        end
    end

    // Main sequence: initialise every input, reset once, run the tests in turn.
    initial begin
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_DELIMITER;
        cfg_data      <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_RECEIVE;
        in_ch.rx_byte <= '0;
        steady        = 1'b0;
        hold_request  = 0;
        hold_left     = 0;
        reset_ring_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_port_control();
        test_default_delimiter();
        test_line_rule_extremes();
        test_ring_overflow();
        test_output_backpressure();
        test_random_lines();

        // Waiting on past the last drained result catches any stray extra result.
        repeat (8) @(posedge i_clk);

        $display("Sent %0d items and checked %0d results across %0d random rule phases.",
                 items_sent, results_checked, PHASE_COUNT);
        $display("Lines ended by delimiter %0d, by length %0d; ring overflows %0d.",
                 delim_ends, len_ends, overflow_seen);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failing results.", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/urls_pkg.sv
sv/urls_in_if.sv
sv/urls_out_if.sv
sv/urls_line_unit.sv
sv/uart_rx_ring_line_splitter.sv
sv/urls_checker.sv
tb/sv/testbench.sv
